/* sv/tsor_pkg.sv */
`timescale 1ns / 1ps

package tsor_pkg;

    // Telnet command bytes.
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;

    // Negotiated options.
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;

    // Escape sequence and line ending bytes.
    localparam logic [7:0] B_ESC   = 8'h1B;
    localparam logic [7:0] B_LBRK  = 8'h5B;
    localparam logic [7:0] B_CHR_D = 8'h44;
    localparam logic [7:0] B_CHR_C = 8'h43;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] B_LF    = 8'h0A;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PEER  = 2'd1;
    localparam logic [1:0] KIND_LEFT  = 2'd2;
    localparam logic [1:0] KIND_RIGHT = 2'd3;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    // The results caused by one received byte, up to three.
    typedef struct packed {
        logic [1:0]        cnt;
        result_t [2:0]     item;
    } group_t;

    // Builds a three-byte negotiation reply: IAC, verb, option.
    function automatic group_t make_reply(input logic [7:0] verb, input logic [7:0] opt);
        group_t g;
        g.cnt = 2'd3;
        g.item[0] = '{kind: KIND_PEER, value: B_IAC, last: 1'b0};
        g.item[1] = '{kind: KIND_PEER, value: verb,  last: 1'b0};
        g.item[2] = '{kind: KIND_PEER, value: opt,   last: 1'b1};
        return g;
    endfunction

    // Builds a group that holds a single result.
    function automatic group_t make_single(input logic [1:0] kind, input logic [7:0] value);
        group_t g;
        g = '0;
        g.cnt = 2'd1;
        g.item[0] = '{kind: kind, value: value, last: 1'b1};
        return g;
    endfunction

endpackage

/* sv/tsor_if.sv */
`timescale 1ns / 1ps

// Channel that carries received bytes into the block.
interface tsor_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Channel that carries result items out of the block.
interface tsor_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

/* sv/tsor_parser.sv */
`timescale 1ns / 1ps

module tsor_parser
    import tsor_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output group_t     group
);

    localparam logic [2:0] ST_DATA = 3'd0;
    localparam logic [2:0] ST_IAC  = 3'd1;
    localparam logic [2:0] ST_CMD  = 3'd2;
    localparam logic [2:0] ST_ESC  = 3'd3;
    localparam logic [2:0] ST_BRK  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [7:0] verb_reg;
    logic [7:0] verb_next;
    logic       cr_seen_reg;
    logic       cr_seen_next;

    logic       is_verb;
    logic       pend_will_wont;

    assign is_verb = (rx_byte == B_WILL) || (rx_byte == B_WONT) ||
                     (rx_byte == B_DO) || (rx_byte == B_DONT);
    assign pend_will_wont = (verb_reg == B_WILL) || (verb_reg == B_WONT);

    // Classify the byte against the protocol state and build its results.
    always_comb
    begin
        state_next   = ST_DATA;
        verb_next    = verb_reg;
        cr_seen_next = cr_seen_reg;
        group        = '0;
        unique case (state_reg)
            ST_DATA:
            begin
                if (rx_byte == B_IAC)
                begin
                    state_next = ST_IAC;
                end
                else if (rx_byte == B_ESC)
                begin
                    state_next = ST_ESC;
                end
                else if (rx_byte == B_LF && cr_seen_reg)
                begin
                    cr_seen_next = 1'b0;
                end
                else
                begin
                    cr_seen_next = (rx_byte == B_CR);
                    group        = make_single(KIND_DATA, rx_byte);
                end
            end
            ST_IAC:
            begin
                if (rx_byte == B_IAC)
                begin
                    group = make_single(KIND_PEER, B_IAC);
                end
                else if (is_verb)
                begin
                    verb_next  = rx_byte;
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                verb_next = 8'd0;
                if (rx_byte == OPT_ECHO || rx_byte == OPT_SGA)
                begin
                    if (verb_reg == B_DO)
                    begin
                        group = make_reply(B_WILL, rx_byte);
                    end
                    else if (verb_reg == B_DONT)
                    begin
                        group = make_reply(B_WONT, rx_byte);
                    end
                    else if (verb_reg == B_WILL && rx_byte == OPT_SGA)
                    begin
                        group = make_reply(B_DO, rx_byte);
                    end
                    else if (pend_will_wont)
                    begin
                        group = make_reply(B_DONT, rx_byte);
                    end
                end
                else if (pend_will_wont)
                begin
                    group = make_reply(B_DONT, rx_byte);
                end
                else
                begin
                    group = make_reply(B_WONT, rx_byte);
                end
            end
            ST_ESC:
            begin
                state_next = (rx_byte == B_LBRK) ? ST_BRK : ST_DATA;
            end
            ST_BRK:
            begin
                if (rx_byte == B_CHR_D)
                begin
                    group = make_single(KIND_LEFT, 8'd0);
                end
                else if (rx_byte == B_CHR_C)
                begin
                    group = make_single(KIND_RIGHT, 8'd0);
                end
            end
            default:
            begin
                state_next = ST_DATA;
            end
        endcase
    end

    // Protocol state advances on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_DATA;
            verb_reg    <= 8'd0;
            cr_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            verb_reg    <= verb_next;
            cr_seen_reg <= cr_seen_next;
        end
    end

endmodule

/* sv/tsor_emitter.sv */
`timescale 1ns / 1ps

module tsor_emitter
    import tsor_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  group_t  group,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    logic [1:0]    cnt_reg;
    logic [1:0]    ptr_reg;
    result_t [2:0] items_reg;
    logic          out_valid_reg;
    result_t       out_item_reg;

    logic          out_free;
    logic          move;
    logic          load;

    // A result moves to the output register whenever that register is free.
    assign out_free = !out_valid_reg || out_ready;
    assign move     = (cnt_reg != 2'd0) && out_free;
    assign in_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && move);
    assign load     = in_valid && in_ready;

    // Group buffer holds the results of the latest request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= group.cnt;
            ptr_reg <= 2'd0;
        end
        else if (move)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            ptr_reg <= ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            items_reg <= group.item;
        end
    end

    // Output register parts the result side from the group buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_item_reg <= items_reg[ptr_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* sv/telnet_stream_option_responder.sv */
`timescale 1ns / 1ps

// Telnet receive-side option responder. Each received byte is classified in
// the cycle it is accepted and its results (none, one, or a three-byte
// negotiation reply) are handed out one per cycle through an output register
// while the output is not stalled. A byte that yields no result or a single
// result does not hold the input back, so plain data flows at one byte per
// clock while the output is not stalled; a WILL/WONT/DO/DONT option byte yields
// three results, and the next byte waits until the last of them moves into the
// single output register. A new byte is taken while the previous result still waits at the output.

module telnet_stream_option_responder
    import tsor_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tsor_in_if.sink    in_ch,
    tsor_out_if.source out_ch
);

    logic    in_ready;
    logic    accept;
    group_t  group;
    result_t out_item;
    logic    out_valid;

    assign accept = in_ch.valid && in_ready;

    tsor_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (in_ch.rx_byte),
        .group   (group)
    );

    tsor_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .group     (group),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.kind  = out_item.kind;
    assign out_ch.value = out_item.value;
    assign out_ch.last  = out_item.last;

endmodule
